// File: sv/lzw_pkg.sv
// Package for the LZW fixed-width compressor.
// Shared types and constants; no dependencies.
package lzw_pkg;
	localparam int HashBits = 17;
	localparam int KeyBits = 24;
	localparam logic [31:0] HashMult = 32'd2654435761;

	typedef struct packed {
		logic start;
		logic ld_hash;
		logic probe_rd;
		logic ins_wr;
		logic clr_wr;
		logic hit_upd;
		logic miss_upd;
		logic emit_prefix;
		logic emit_last;
		logic emit_pad;
		logic stream_rst;
	} cmd_t;

	typedef struct packed {
		logic slot_empty;
		logic key_match;
		logic can_add;
		logic have_prefix;
		logic last;
		logic pack_busy;
		logic pad_needed;
		logic clr_done;
	} sts_t;

	function automatic logic [HashBits-1:0] slot_of(input logic [KeyBits-1:0] key);
		logic [31:0] p;
		p = {8'd0, key} * HashMult;
		return p[31 -: HashBits];
	endfunction
endpackage

// File: sv/lzw_if.sv
// Valid/ready channel interface carrying one byte and a last flag.
// Depends on nothing.
interface lzw_if;
	logic valid;
	logic ready;
	logic [7:0] data;
	logic last;
	modport source(output valid, data, last, input ready);
	modport sink(input valid, data, last, output ready);
endinterface

// File: sv/lzw_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module lzw_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: sv/lzw_ctrl.sv
// Controller state machine for the LZW compressor.
// Depends on lzw_pkg.
module lzw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lzw_pkg::sts_t sts,
	output lzw_pkg::cmd_t cmd
);
	typedef enum logic [9:0] {
		S_CLR = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_HASH = 10'b0000000100,
		S_RD = 10'b0000001000,
		S_DRD = 10'b0000010000,
		S_CMP = 10'b0000100000,
		S_INS = 10'b0001000000,
		S_LAST = 10'b0010000000,
		S_PAD = 10'b0100000000,
		S_DRN = 10'b1000000000
	} state_t;
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = !sts.pack_busy;
				if (in_valid && !sts.pack_busy) begin
					cmd.start = 1'b1;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				if (!sts.have_prefix) begin
					cmd.hit_upd = 1'b1;
					state_d = sts.last ? S_LAST : S_IDLE;
				end else begin
					cmd.ld_hash = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_DRD;
			end
			S_DRD: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.slot_empty) begin
					cmd.emit_prefix = 1'b1;
					state_d = S_INS;
				end else if (sts.key_match) begin
					cmd.hit_upd = 1'b1;
					state_d = sts.last ? S_LAST : S_IDLE;
				end else begin
					cmd.probe_rd = 1'b1;
					state_d = S_RD;
				end
			end
			S_INS: begin
				if (!sts.pack_busy) begin
					cmd.ins_wr = sts.can_add;
					cmd.miss_upd = 1'b1;
					state_d = sts.last ? S_LAST : S_IDLE;
				end
			end
			S_LAST: begin
				if (!sts.pack_busy) begin
					cmd.emit_prefix = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				if (!sts.pack_busy) begin
					if (sts.pad_needed) cmd.emit_pad = 1'b1;
					state_d = S_DRN;
				end
			end
			S_DRN: begin
				if (!sts.pack_busy) begin
					cmd.stream_rst = 1'b1;
					state_d = S_CLR;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end
endmodule

// File: sv/lzw_dp.sv
// Datapath: probe table, dictionary RAM, prefix state and bit packer.
// Depends on lzw_pkg and lzw_ram.
module lzw_dp #(
	parameter int MaxCodeBits = 16
) (
	input logic clk,
	input logic arst_n,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic [4:0] code_width,
	input lzw_pkg::cmd_t cmd,
	output lzw_pkg::sts_t sts,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic out_last
);
	localparam int HB = lzw_pkg::HashBits;
	localparam int DictDepth = (1 << MaxCodeBits) - 256;
	localparam int DA = $clog2(DictDepth);
	localparam int CW = MaxCodeBits;
	localparam int KB = lzw_pkg::KeyBits;

	logic [7:0] byte_q;
	logic last_q;
	logic [CW-1:0] prefix_q;
	logic pvalid_q;
	logic [CW:0] next_q;
	logic [HB-1:0] slot_q;
	logic [KB-1:0] key_q;
	logic [HB:0] clr_q;
	logic [HB-1:0] p_addr;
	logic p_we;
	logic [CW-1:0] p_wdata, p_rdata;
	logic [DA-1:0] d_addr;
	logic [KB-1:0] d_rdata;
	logic [4:0] w;
	logic [CW:0] limit;

	// packer
	logic [CW+6:0] buf_q;
	logic [4:0] cnt_q;
	logic [7:0] ob_q;
	logic ol_q, ov_q;
	logic pend_last_q;
	logic fin_q;

	logic [CW+6:0] ext;
	logic [CW-1:0] emit_code;
	logic drain;

	always_comb begin
		w = code_width;
		if (w < 5'd8) w = 5'd8;
		if (w > 5'(MaxCodeBits)) w = 5'(MaxCodeBits);
		limit = (CW+1)'(1) << w;
	end

	always_comb begin
		p_addr = slot_q;
		p_we = 1'b0;
		p_wdata = next_q[CW-1:0];
		if (cmd.clr_wr) begin
			p_addr = clr_q[HB-1:0];
			p_we = 1'b1;
			p_wdata = '0;
		end else if (cmd.ins_wr) begin
			p_we = 1'b1;
		end
	end

	lzw_ram #(.Width(CW), .Depth(1 << HB)) u_probe (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata)
	);

	// slot word is read in S_RD, dictionary entry in S_DRD
	always_comb begin
		d_addr = DA'(p_rdata - CW'(256));
		if (cmd.ins_wr) d_addr = DA'(next_q - (CW+1)'(256));
	end

	lzw_ram #(.Width(KB), .Depth(DictDepth)) u_dict (
		.clk(clk), .we(cmd.ins_wr), .addr(d_addr), .wdata(key_q), .rdata(d_rdata)
	);

	always_comb begin
		emit_code = cmd.emit_prefix ? prefix_q : '0;
		ext = (buf_q << w) | ((CW+7)'(emit_code) & (((CW+7)'(1) << w) - (CW+7)'(1)));
		drain = !cmd.emit_prefix && !cmd.emit_pad && (cnt_q >= 5'd8)
			&& (!ov_q || out_ready);
	end

	always_comb begin
		sts.slot_empty = (p_rdata == '0);
		sts.key_match = (d_rdata == key_q);
		sts.can_add = ({1'b0, next_q} < {1'b0, limit}) && (next_q < (CW+1)'(1 << CW));
		sts.have_prefix = pvalid_q;
		sts.last = last_q;
		sts.pack_busy = (cnt_q >= 5'd8) || (ov_q && !out_ready);
		sts.pad_needed = (cnt_q != 5'd0);
		sts.clr_done = clr_q[HB];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (cmd.ld_hash) begin
			key_q <= KB'({prefix_q, byte_q});
			slot_q <= lzw_pkg::slot_of(KB'({prefix_q, byte_q}));
		end else if (cmd.probe_rd) begin
			slot_q <= slot_q + HB'(1);
		end
		if (cmd.hit_upd) prefix_q <= pvalid_q ? p_rdata : CW'(byte_q);
		if (cmd.miss_upd) prefix_q <= CW'(byte_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= 1'b0;
			next_q <= (CW+1)'(256);
			clr_q <= '0;
			buf_q <= '0;
			cnt_q <= '0;
			ov_q <= 1'b0;
			ol_q <= 1'b0;
			ob_q <= '0;
			pend_last_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + (HB+1)'(1);
			if (cmd.hit_upd) pvalid_q <= 1'b1;
			if (cmd.ins_wr) next_q <= next_q + (CW+1)'(1);
			if (drain) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			if (cmd.emit_prefix) begin
				buf_q <= ext;
				cnt_q <= cnt_q + w;
				pend_last_q <= 1'b0;
			end else if (cmd.emit_pad) begin
				buf_q <= buf_q << (5'd8 - cnt_q);
				cnt_q <= 5'd8;
				pend_last_q <= 1'b1;
			end else if (drain) begin
				cnt_q <= cnt_q - 5'd8;
				ob_q <= 8'(buf_q >> (cnt_q - 5'd8));
				// final word: the pad word, or the word that empties the final code
				ol_q <= fin_q && (pend_last_q || cnt_q == 5'd8);
				buf_q <= buf_q & (((CW+7)'(1) << (cnt_q - 5'd8)) - (CW+7)'(1));
			end
			if (cmd.emit_last) fin_q <= 1'b1;
			else if (cmd.stream_rst) fin_q <= 1'b0;
			if (cmd.stream_rst) begin
				pvalid_q <= 1'b0;
				next_q <= (CW+1)'(256);
				clr_q <= '0;
				pend_last_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_byte = ob_q;
	assign out_last = ol_q;
endmodule

// File: sv/lzw_fixed_width_compressor_top.sv
// LZW compressor with fixed-width codes, top level.
// Input channel takes bytes with a last flag; output channel gives packed
// bytes MSB first, last flag on the final packed byte of a stream.
// Code width is set through the APB port, register 0 at address 0.
// A byte on a dictionary hit passes accept, hash, probe table read,
// dictionary read and compare. A miss adds an insert step that waits
// while the packer is busy. Each further probe of the hash chain repeats
// the reads and the compare. A stream's first byte takes accept and hash.
// Packed bytes leave one per cycle while the receiver is ready.
// The final byte adds the last code, an optional pad byte and the drain.
// After reset, and after each stream end, a clearing pass walks the
// 131072-entry probe table, one entry a cycle, before a byte is taken.
// When the receiver stalls the output register holds its word and the
// block stops taking bytes until the packer drains.
// Depends on lzw_pkg, lzw_if, lzw_ram, lzw_ctrl, lzw_dp.
module lzw_fixed_width_compressor_top #(
	parameter int MaxCodeBits = 16
) (
	input logic clk,
	input logic arst_n,
	lzw_if.sink in_ch,
	lzw_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [4:0] code_width_q;
	lzw_pkg::cmd_t cmd;
	lzw_pkg::sts_t sts;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) code_width_q <= 5'd12;
		else if (psel && penable && pwrite && paddr == 2'd0) code_width_q <= pwdata[4:0];
	end
	assign prdata = (paddr == 2'd0) ? {27'd0, code_width_q} : 32'd0;

	lzw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	lzw_dp #(.MaxCodeBits(MaxCodeBits)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_byte(in_ch.data), .in_last(in_ch.last),
		.code_width(code_width_q), .cmd(cmd), .sts(sts),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_byte(out_ch.data), .out_last(out_ch.last)
	);
endmodule
